FILE: rtl/bfmc_pkg.sv
// Shared constants for the 2x2 box filter mipmap chain generator.
package bfmc_pkg;

    // Default largest supported texture side, as log2
    localparam int MAX_SIDE_LOG2_DEF = 10;

    // Fixed field widths
    localparam int SIDE_LOG2_W = 4;
    localparam int CH_W        = 8;
    localparam int SUM_W       = 10;
    localparam int LEVEL_W     = 4;
    localparam int COORD_W     = 9;

    // Side register value after reset
    localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RST = 4'd8;

endpackage

FILE: rtl/box_filter_mipmap_chain.sv
// Streaming mipmap chain generator: 2x2 box filter over a square RGB888 texture.
//
// Usage: base texels enter on the input channel (in_valid / in_stall, fields
// red, green, blue) in row-major order. Every completed 2x2 block of any level
// leaves on the output channel (out_valid / out_stall) tagged with level,
// row_index and col_index, lowest level first; last_of_run marks the final
// result of one input request, chain_done marks the 1x1 texel.
// side_log2 is written through side_log2_wr while the block is idle; a write
// restarts the chain at texel (0,0). A side of one swallows all input.
// Path: a level-1 result passes the step register and then the output
// register; each further level adds one more pass through the step register.
// Flow: every request costs one pass through the shared partial-sum memory
// per level it touches, and a new texel waits while a completed block carries
// up to the next level.
// The memory read-modify-write path has one read port, one write port,
// a registered read and one-deep write forwarding.
// Reset: side_log2 returns to 8, all level counters clear, pipeline empties.
// The memory needs no clearing pass: each block opens with a plain write.
// A stalled output holds its result and backs up into in_stall.
module box_filter_mipmap_chain #(
    parameter int MAX_SIDE_LOG2 = bfmc_pkg::MAX_SIDE_LOG2_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              side_log2_wr,
    input  logic [bfmc_pkg::SIDE_LOG2_W-1:0]  side_log2,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bfmc_pkg::CH_W-1:0]         red,
    input  logic [bfmc_pkg::CH_W-1:0]         green,
    input  logic [bfmc_pkg::CH_W-1:0]         blue,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bfmc_pkg::LEVEL_W-1:0]      level,
    output logic [bfmc_pkg::COORD_W-1:0]      row_index,
    output logic [bfmc_pkg::COORD_W-1:0]      col_index,
    output logic [bfmc_pkg::CH_W-1:0]         out_red,
    output logic [bfmc_pkg::CH_W-1:0]         out_green,
    output logic [bfmc_pkg::CH_W-1:0]         out_blue,
    output logic                              last_of_run,
    output logic                              chain_done
);
    import bfmc_pkg::*;

    localparam int DEPTH = 1 << MAX_SIDE_LOG2;
    localparam int AW    = MAX_SIDE_LOG2;
    localparam int CW    = MAX_SIDE_LOG2;
    localparam int NLVL  = MAX_SIDE_LOG2 + 1;
    localparam int IW    = $clog2(NLVL);
    localparam int LW    = $clog2(NLVL + 1);
    localparam int MW    = 3 * SUM_W;

    // One level step between memory read and write-back
    typedef struct packed {
        logic [LW-1:0]      lvl;
        logic [AW-1:0]      addr;
        logic               fresh;
        logic               done;
        logic               has_up;
        logic               up_done;
        logic               chain_end;
        logic [CH_W-1:0]    r;
        logic [CH_W-1:0]    g;
        logic [CH_W-1:0]    b;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } step_t;

    // configuration and level position counters
    logic [SIDE_LOG2_W-1:0] side_log2_reg;
    logic [CW-1:0]          col_reg [NLVL];
    logic [CW-1:0]          row_reg [NLVL];

    // partial sum memory
    logic [MW-1:0]          sum_mem [DEPTH];
    logic [MW-1:0]          rd_data_reg;
    logic                   fwd_hit_reg;
    logic [MW-1:0]          fwd_data_reg;

    // step register and output register
    logic                   s1_valid_reg;
    step_t                  s1_reg;
    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [COORD_W-1:0]     row_idx_reg;
    logic [COORD_W-1:0]     col_idx_reg;
    logic [CH_W-1:0]        r_out_reg;
    logic [CH_W-1:0]        g_out_reg;
    logic [CH_W-1:0]        b_out_reg;
    logic                   last_reg;
    logic                   chain_reg;

    logic [LW-1:0]          n_eff;
    logic                   s1_go;
    logic                   carry;

    logic                   iss_valid;
    logic [LW-1:0]          iss_lvl;
    logic [LW-1:0]          iss_up;
    logic [CH_W-1:0]        iss_r;
    logic [CH_W-1:0]        iss_g;
    logic [CH_W-1:0]        iss_b;
    logic [CW-1:0]          cur_col;
    logic [CW-1:0]          cur_row;
    logic [CW:0]            side_full;
    logic [CW-1:0]          side_m1;
    logic [CW-1:0]          col_next;
    logic [CW-1:0]          row_next;
    logic [AW:0]            base_full;
    logic [AW-1:0]          iss_addr;
    logic                   up_odd;
    step_t                  s1_next;

    logic [MW-1:0]          old_sum;
    logic [SUM_W-1:0]       sum_r;
    logic [SUM_W-1:0]       sum_g;
    logic [SUM_W-1:0]       sum_b;
    logic [MW-1:0]          wr_data;
    logic [CH_W-1:0]        avg_r;
    logic [CH_W-1:0]        avg_g;
    logic [CH_W-1:0]        avg_b;

    // effective side, clamped to the supported maximum
    assign n_eff = (side_log2_reg > SIDE_LOG2_W'(MAX_SIDE_LOG2)) ? LW'(MAX_SIDE_LOG2)
                                                                : LW'(side_log2_reg);

    // accumulate the step in flight; forwarding covers a write to the same entry
    always_comb
    begin
        old_sum = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        if (s1_reg.fresh)
        begin
            sum_r = SUM_W'(s1_reg.r);
            sum_g = SUM_W'(s1_reg.g);
            sum_b = SUM_W'(s1_reg.b);
        end
        else
        begin
            sum_r = old_sum[3*SUM_W-1:2*SUM_W] + SUM_W'(s1_reg.r);
            sum_g = old_sum[2*SUM_W-1:SUM_W]   + SUM_W'(s1_reg.g);
            sum_b = old_sum[SUM_W-1:0]         + SUM_W'(s1_reg.b);
        end
        wr_data = {sum_r, sum_g, sum_b};
        avg_r   = sum_r[SUM_W-1:2];
        avg_g   = sum_g[SUM_W-1:2];
        avg_b   = sum_b[SUM_W-1:2];
    end

    // handshake and step scheduling
    assign s1_go    = s1_valid_reg && (!s1_reg.done || !out_valid_reg || !out_stall);
    assign carry    = s1_valid_reg && s1_reg.done && s1_reg.has_up;
    assign in_stall = s1_valid_reg && (!s1_go || carry);

    // pick the next step: a carried result beats a new texel
    always_comb
    begin
        iss_valid = 1'b0;
        iss_lvl   = '0;
        iss_r     = red;
        iss_g     = green;
        iss_b     = blue;
        if (carry && s1_go)
        begin
            iss_valid = 1'b1;
            iss_lvl   = s1_reg.lvl + 1'b1;
            iss_r     = avg_r;
            iss_g     = avg_g;
            iss_b     = avg_b;
        end
        else if (in_valid && !in_stall && (n_eff != '0))
        begin
            iss_valid = 1'b1;
        end
    end

    // counter lookup, next position and memory address for the issued step
    always_comb
    begin
        iss_up    = iss_lvl + 1'b1;
        cur_col   = col_reg[iss_lvl[IW-1:0]];
        cur_row   = row_reg[iss_lvl[IW-1:0]];
        side_full = (CW+1)'(1) << (n_eff - iss_lvl);
        side_m1   = CW'(side_full - 1'b1);
        col_next  = cur_col + 1'b1;
        row_next  = cur_row;
        if (cur_col == side_m1)
        begin
            col_next = '0;
            row_next = (cur_row == side_m1) ? '0 : cur_row + 1'b1;
        end
        base_full = (AW+1)'(DEPTH) - ((AW+1)'(DEPTH) >> iss_lvl);
        iss_addr  = AW'(base_full) + AW'(cur_col >> 1);
        up_odd    = 1'b0;
        if (iss_up < n_eff)
        begin
            up_odd = col_reg[iss_up[IW-1:0]][0] && row_reg[iss_up[IW-1:0]][0];
        end

        s1_next.lvl       = iss_lvl;
        s1_next.addr      = iss_addr;
        s1_next.fresh     = !cur_col[0] && !cur_row[0];
        s1_next.done      = cur_col[0] && cur_row[0];
        s1_next.has_up    = iss_up < n_eff;
        s1_next.up_done   = up_odd;
        s1_next.chain_end = iss_up == n_eff;
        s1_next.r         = iss_r;
        s1_next.g         = iss_g;
        s1_next.b         = iss_b;
        s1_next.row       = COORD_W'(cur_row >> 1);
        s1_next.col       = COORD_W'(cur_col >> 1);
    end

    // side register and level counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_log2_reg <= SIDE_LOG2_RST;
            for (int i = 0; i < NLVL; i++)
            begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else if (side_log2_wr)
        begin
            side_log2_reg <= side_log2;
            for (int i = 0; i < NLVL; i++)
            begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else if (iss_valid)
        begin
            col_reg[iss_lvl[IW-1:0]] <= col_next;
            row_reg[iss_lvl[IW-1:0]] <= row_next;
        end
    end

    // partial sum memory: write-back of the step in flight, read for the next
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            sum_mem[s1_reg.addr] <= wr_data;
        end
        if (iss_valid)
        begin
            rd_data_reg  <= sum_mem[iss_addr];
            fwd_hit_reg  <= s1_go && (iss_addr == s1_reg.addr);
            fwd_data_reg <= wr_data;
        end
    end

    // step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (iss_valid)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss_valid)
        begin
            s1_reg <= s1_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_reg.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_reg.done)
        begin
            level_reg   <= LEVEL_W'(s1_reg.lvl + 1'b1);
            row_idx_reg <= s1_reg.row;
            col_idx_reg <= s1_reg.col;
            r_out_reg   <= avg_r;
            g_out_reg   <= avg_g;
            b_out_reg   <= avg_b;
            last_reg    <= !(s1_reg.has_up && s1_reg.up_done);
            chain_reg   <= s1_reg.chain_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign level       = level_reg;
    assign row_index   = row_idx_reg;
    assign col_index   = col_idx_reg;
    assign out_red     = r_out_reg;
    assign out_green   = g_out_reg;
    assign out_blue    = b_out_reg;
    assign last_of_run = last_reg;
    assign chain_done  = chain_reg;

endmodule

FILE: tb/sv/tb_box_filter_mipmap_chain.sv
// Self-checking testbench for the 2x2 box filter mipmap chain generator.
module tb_box_filter_mipmap_chain;
    import bfmc_pkg::*;

    localparam int MAX_LOG2      = MAX_SIDE_LOG2_DEF;
    localparam int SUM_DEPTH     = 1 << MAX_LOG2;
    localparam int ITEMS         = 330;
    localparam int DIR_ROWS      = 25;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int CYCLE_LIMIT   = 300000;

    // one result texel of some mip level
    typedef struct packed {
        logic [LEVEL_W-1:0] lvl;
        logic [COORD_W-1:0] row_i;
        logic [COORD_W-1:0] col_i;
        logic [CH_W-1:0]    ch_r;
        logic [CH_W-1:0]    ch_g;
        logic [CH_W-1:0]    ch_b;
        logic               last;
        logic               done;
    } mip_texel_t;

    typedef enum logic {ROW_TEXEL, ROW_SIDE} row_kind_t;

    // directed step: a side write or a texel with its typed-in outcome
    typedef struct packed {
        row_kind_t              kind;
        logic [SIDE_LOG2_W-1:0] side;
        logic [CH_W-1:0]        r;
        logic [CH_W-1:0]        g;
        logic [CH_W-1:0]        b;
        logic                   has_mip;
        mip_texel_t             mip;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   side_log2_wr = 1'b0;
    logic [SIDE_LOG2_W-1:0] side_log2    = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [CH_W-1:0]        red          = '0;
    logic [CH_W-1:0]        green        = '0;
    logic [CH_W-1:0]        blue         = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [LEVEL_W-1:0]     level;
    logic [COORD_W-1:0]     row_index;
    logic [COORD_W-1:0]     col_index;
    logic [CH_W-1:0]        out_red;
    logic [CH_W-1:0]        out_green;
    logic [CH_W-1:0]        out_blue;
    logic                   last_of_run;
    logic                   chain_done;

    box_filter_mipmap_chain dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .side_log2_wr (side_log2_wr),
        .side_log2    (side_log2),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .level        (level),
        .row_index    (row_index),
        .col_index    (col_index),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .last_of_run  (last_of_run),
        .chain_done   (chain_done)
    );

    // shadow state of the filter chain
    logic [SIDE_LOG2_W-1:0] side_cfg;
    logic [3*SUM_W-1:0]     block_sums [SUM_DEPTH];
    logic [MAX_LOG2-1:0]    col_pos [MAX_LOG2+1];
    logic [MAX_LOG2-1:0]    row_pos [MAX_LOG2+1];
    mip_texel_t             mip_expect [$];

    dir_row_t dir_steps [DIR_ROWS];
    int       errors        = 0;
    int       cycle_count   = 0;
    int       texel_count   = 0;
    int       send_idle_pct = 25;
    int       stall_pct     = 66;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic dir_row_t quiet_row(input int r, g, b);
        dir_row_t s;
        s = '0;
        s.kind = ROW_TEXEL;
        s.r = CH_W'(r);
        s.g = CH_W'(g);
        s.b = CH_W'(b);
        return s;
    endfunction

    // texel that closes the single 2x2 block of a 2x2 texture
    function automatic dir_row_t mip_row(input int r, g, b, er, eg, eb);
        dir_row_t s;
        s = quiet_row(r, g, b);
        s.has_mip = 1'b1;
        s.mip = '{lvl: LEVEL_W'(1), row_i: '0, col_i: '0,
                  ch_r: CH_W'(er), ch_g: CH_W'(eg), ch_b: CH_W'(eb),
                  last: 1'b1, done: 1'b1};
        return s;
    endfunction

    function automatic dir_row_t side_row(input int v);
        dir_row_t s;
        s = '0;
        s.kind = ROW_SIDE;
        s.side = SIDE_LOG2_W'(v);
        return s;
    endfunction

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Push one base texel through every level it reaches; each completed
    // block becomes a result and feeds the next level.
    function automatic void filter_texel(input logic [CH_W-1:0] r, g, b, input bit keep);
        int          n;
        int          l;
        int          side;
        int          col;
        int          row;
        int          idx;
        bit          closes;
        logic [SUM_W-1:0] vr;
        logic [SUM_W-1:0] vg;
        logic [SUM_W-1:0] vb;
        mip_texel_t  res;
        mip_texel_t  run [$];
        n = (side_cfg > MAX_LOG2) ? MAX_LOG2 : int'(side_cfg);
        vr = SUM_W'(r);
        vg = SUM_W'(g);
        vb = SUM_W'(b);
        for (l = 0; l < n; l++)
        begin
            side = 1 << (n - l);
            col = int'(col_pos[l]);
            row = int'(row_pos[l]);
            idx = (SUM_DEPTH - (SUM_DEPTH >> l) + (col >> 1)) % SUM_DEPTH;
            // top-left texel opens the block sum
            if (!row[0] && !col[0])
                block_sums[idx] = {vr, vg, vb};
            else
                block_sums[idx] = block_sums[idx] + {vr, vg, vb};
            closes = row[0] && col[0];
            // raster advance, wrapping at the end of the level
            if (col + 1 >= side)
            begin
                col_pos[l] = '0;
                row_pos[l] = (row + 1 >= side) ? '0 : MAX_LOG2'(row + 1);
            end
            else
                col_pos[l] = MAX_LOG2'(col + 1);
            if (!closes)
                break;
            vr = block_sums[idx][3*SUM_W-1:2*SUM_W] >> 2;
            vg = block_sums[idx][2*SUM_W-1:SUM_W] >> 2;
            vb = block_sums[idx][SUM_W-1:0] >> 2;
            res.lvl   = LEVEL_W'(l + 1);
            res.row_i = COORD_W'(row >> 1);
            res.col_i = COORD_W'(col >> 1);
            res.ch_r  = vr[CH_W-1:0];
            res.ch_g  = vg[CH_W-1:0];
            res.ch_b  = vb[CH_W-1:0];
            res.last  = 1'b0;
            res.done  = (l + 1 == n);
            run.push_back(res);
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        if (keep)
            foreach (run[i])
                mip_expect.push_back(run[i]);
    endfunction

    // one input request; the shadow model runs once it is accepted
    task automatic send_texel(input logic [CH_W-1:0] r, g, b, input bit keep);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (side_cfg != 0)
            texel_count++;
        filter_texel(r, g, b, keep);
    endtask

    // side write once everything in flight has drained
    task automatic write_side(input logic [SIDE_LOG2_W-1:0] v);
        in_valid <= 1'b0;
        while (mip_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        side_log2_wr <= 1'b1;
        side_log2 <= v;
        @(posedge clk);
        side_log2_wr <= 1'b0;
        side_cfg = v;
        foreach (col_pos[i])
        begin
            col_pos[i] = '0;
            row_pos[i] = '0;
        end
    endtask

    // results: compare against the oldest expectation, stall at random
    always @(posedge clk)
    begin
        mip_texel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (mip_expect.size() == 0)
            begin
                $error("unexpected result: level %0d row %0d col %0d",
                       level, row_index, col_index);
                errors++;
            end
            else
            begin
                want = mip_expect.pop_front();
                check_field("level", int'(want.lvl), int'(level));
                check_field("row_index", int'(want.row_i), int'(row_index));
                check_field("col_index", int'(want.col_i), int'(col_index));
                check_field("out_red", int'(want.ch_r), int'(out_red));
                check_field("out_green", int'(want.ch_g), int'(out_green));
                check_field("out_blue", int'(want.ch_b), int'(out_blue));
                check_field("last_of_run", int'(want.last), int'(last_of_run));
                check_field("chain_done", int'(want.done), int'(chain_done));
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial
    begin
        int roll;
        int burst;
        int tex;
        int drain;
        logic [SIDE_LOG2_W-1:0] side_v;

        side_cfg = SIDE_LOG2_RST;
        foreach (block_sums[i])
            block_sums[i] = '0;
        foreach (col_pos[i])
        begin
            col_pos[i] = '0;
            row_pos[i] = '0;
        end

        dir_steps = '{
            // reset side of 256: no block closes this early
            quiet_row(255, 255, 255),
            quiet_row(0, 0, 0),
            // side of one swallows input
            side_row(0),
            quiet_row(255, 0, 255),
            quiet_row(1, 2, 3),
            // oversized and largest sides
            side_row(15),
            quiet_row(170, 85, 170),
            side_row(10),
            quiet_row(0, 255, 0),
            // 2x2 texture: full scale, then truncation per channel
            side_row(1),
            quiet_row(255, 255, 255),
            quiet_row(255, 255, 255),
            quiet_row(255, 255, 255),
            mip_row(255, 255, 255, 255, 255, 255),
            quiet_row(3, 7, 255),
            quiet_row(0, 0, 255),
            quiet_row(0, 0, 255),
            mip_row(0, 0, 255, 0, 1, 255),
            // rewrite mid texture restarts at texel (0,0)
            quiet_row(9, 9, 9),
            quiet_row(9, 9, 9),
            side_row(1),
            quiet_row(10, 20, 30),
            quiet_row(10, 20, 30),
            quiet_row(10, 20, 30),
            mip_row(10, 20, 30, 10, 20, 30)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed steps
        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == ROW_SIDE)
                write_side(dir_steps[i].side);
            else
            begin
                send_texel(dir_steps[i].r, dir_steps[i].g, dir_steps[i].b, 1'b0);
                if (dir_steps[i].has_mip)
                    mip_expect.push_back(dir_steps[i].mip);
            end
        end

        // random textures, mostly complete, some cut short by a rewrite
        while (texel_count < ITEMS)
        begin
            case (texel_count * 3 / ITEMS)
                0:
                begin
                    send_idle_pct = 25;
                    stall_pct = 66;
                end
                1:
                begin
                    send_idle_pct = 66;
                    stall_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 6)
                side_v = '0;
            else if (roll < 12)
                side_v = SIDE_LOG2_W'($urandom_range(10, 15));
            else
                side_v = SIDE_LOG2_W'($urandom_range(1, 3));
            write_side(side_v);
            if (side_v == 0 || side_v >= 10)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst) send_texel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
            end
            else
            begin
                tex = 1 << (2 * side_v);
                repeat ($urandom_range(1, 2))
                    repeat (tex) send_texel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, tex - 1))
                        send_texel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
            end
        end

        // drain, then watch for stray results
        in_valid <= 1'b0;
        drain = 0;
        while (mip_expect.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mip_expect.size() != 0)
        begin
            $error("%0d expected results never arrived", mip_expect.size());
            errors += mip_expect.size();
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
